// ===== rtl/okrt_pkg.sv =====
// Package for the ordered keyed record table.
// Sizes, operation codes and the structs passed along the cell chain.
// No dependencies.
package okrt_pkg;

    localparam int CAPACITY     = 16;
    localparam int PAYLOAD_BITS = 64;
    localparam int KEY_W        = 32;
    localparam int PORT_PAY_W   = 64;
    localparam int OP_W         = 2;
    localparam int CNT_W        = $clog2(CAPACITY + 1);

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
    localparam logic [OP_W-1:0] OP_LIST   = 2'd3;

    // Broadcast control, common to every cell.
    typedef struct packed {
        logic                    add;
        logic                    del;
        logic                    rot;
        logic [KEY_W-1:0]        key;
        logic [PAYLOAD_BITS-1:0] pay;
    } t_ctl;

    // One stored entry as seen by a neighbour.
    typedef struct packed {
        logic                    vld;
        logic [KEY_W-1:0]        key;
        logic [PAYLOAD_BITS-1:0] pay;
    } t_ent;

endpackage

// ===== rtl/ordered_keyed_record_table_top.sv =====
// Top level of the ordered keyed record table: command decode, record count,
// list sequencing and result register around a chain of okrt_cell.
// Depends on okrt_pkg and okrt_cell.
//
//  channel  | handshake          | fields
//  ---------+--------------------+---------------------------------------------
//  request  | start / busy       | i_op, i_key, i_payload
//  result   | o_valid (strobe)   | o_ok, o_key_out, o_payload_out,
//           |                    | o_used_count, o_full_res, o_last
//
// Add, lookup and delete are applied when accepted; the result is registered and
// shows in the next cycle. During a list the chain rotates one place a cycle and
// the head cell's key is emitted; busy stays high until the last key is out.
// Synchronous active-low reset empties the table. Results cannot be stalled.
module ordered_keyed_record_table_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [okrt_pkg::OP_W-1:0]       i_op,
    input  logic [okrt_pkg::KEY_W-1:0]      i_key,
    input  logic [okrt_pkg::PORT_PAY_W-1:0] i_payload,
    output logic                            o_valid,
    output logic                            o_ok,
    output logic [okrt_pkg::KEY_W-1:0]      o_key_out,
    output logic [okrt_pkg::PORT_PAY_W-1:0] o_payload_out,
    output logic [okrt_pkg::CNT_W-1:0]      o_used_count,
    output logic                            o_full_res,
    output logic                            o_last
);

    localparam int N = okrt_pkg::CAPACITY;

    okrt_pkg::t_ctl                   w_ctl;
    okrt_pkg::t_ent                   w_ent [N];
    logic [N-1:0]                     w_hit;
    logic [N-1:0]                     w_hitc;
    logic [N-1:0]                     w_vld;
    logic [okrt_pkg::PAYLOAD_BITS-1:0] w_lookup;

    logic                             r_busy;
    logic [okrt_pkg::CNT_W-1:0]        r_count;
    logic [okrt_pkg::CNT_W-1:0]        r_remain;
    logic                             r_valid;
    logic                             r_ok;
    logic [okrt_pkg::KEY_W-1:0]        r_key_out;
    logic [okrt_pkg::PORT_PAY_W-1:0]   r_pay_out;
    logic [okrt_pkg::CNT_W-1:0]        r_used;
    logic                             r_full;
    logic                             r_last;

    logic                             n_busy;
    logic [okrt_pkg::CNT_W-1:0]        n_count;
    logic [okrt_pkg::CNT_W-1:0]        n_remain;
    logic                             n_valid;
    logic                             n_ok;
    logic [okrt_pkg::KEY_W-1:0]        n_key_out;
    logic [okrt_pkg::PORT_PAY_W-1:0]   n_pay_out;
    logic                             n_last;

    logic w_acc;
    logic w_found;
    logic w_full;
    logic w_add_ok;
    logic w_list_go;

    assign w_acc     = start && !r_busy;
    assign w_found   = w_hitc[N-1];
    assign w_full    = (r_count == okrt_pkg::CNT_W'(N));
    assign w_add_ok  = w_acc && (i_op == okrt_pkg::OP_ADD) && !w_full && !w_found;
    assign w_list_go = w_acc && (i_op == okrt_pkg::OP_LIST)
                       && (r_count != '0);

    assign w_ctl = '{add: w_add_ok,
                     del: w_acc && (i_op == okrt_pkg::OP_DELETE) && w_found,
                     rot: w_list_go || r_busy,
                     key: i_key,
                     pay: i_payload[okrt_pkg::PAYLOAD_BITS-1:0]};

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            okrt_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_left_vld ((g == 0) ? 1'b1 : w_ent[(g == 0) ? 0 : g - 1].vld),
                .i_hit_in   ((g == 0) ? 1'b0 : w_hitc[(g == 0) ? 0 : g - 1]),
                .i_right    ((g == N - 1) ? '0 : w_ent[(g == N - 1) ? g : g + 1]),
                .i_head     (w_ent[0]),
                .o_ent      (w_ent[g]),
                .o_hit      (w_hit[g]),
                .o_hit_out  (w_hitc[g])
            );
            assign w_vld[g] = w_ent[g].vld;
        end
    endgenerate

    always_comb begin
        w_lookup = '0;
        for (int i = 0; i < N; i++) begin
            w_lookup = w_lookup | (w_hit[i] ? w_ent[i].pay : '0);
        end
    end

    always_comb begin
        n_busy    = r_busy;
        n_count   = r_count;
        n_remain  = r_remain;
        n_valid   = 1'b0;
        n_ok      = 1'b0;
        n_key_out = '0;
        n_pay_out = '0;
        n_last    = 1'b1;
        if (r_busy) begin
            n_valid   = 1'b1;
            n_ok      = 1'b1;
            n_key_out = w_ent[0].key;
            n_last    = (r_remain == okrt_pkg::CNT_W'(1));
            n_remain  = r_remain - okrt_pkg::CNT_W'(1);
            n_busy    = !n_last;
        end else if (w_acc) begin
            n_valid = 1'b1;
            case (i_op)
                okrt_pkg::OP_ADD: begin
                    n_ok    = w_add_ok;
                    n_count = r_count + okrt_pkg::CNT_W'(w_add_ok);
                end
                okrt_pkg::OP_LOOKUP: begin
                    n_ok = w_found;
                    n_pay_out[okrt_pkg::PAYLOAD_BITS-1:0] = w_lookup;
                end
                okrt_pkg::OP_DELETE: begin
                    n_ok    = w_found;
                    n_count = r_count - okrt_pkg::CNT_W'(w_found);
                end
                okrt_pkg::OP_LIST: begin
                    if (w_list_go) begin
                        n_ok      = 1'b1;
                        n_key_out = w_ent[0].key;
                        n_last    = (r_count == okrt_pkg::CNT_W'(1));
                        n_remain  = r_count - okrt_pkg::CNT_W'(1);
                        n_busy    = !n_last;
                    end
                end
                default: begin
                    n_ok = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_count  <= '0;
            r_remain <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_count  <= n_count;
            r_remain <= n_remain;
            r_valid  <= n_valid;
        end
        r_ok      <= n_ok;
        r_key_out <= n_key_out;
        r_pay_out <= n_pay_out;
        r_used    <= n_count;
        r_full    <= (n_count == okrt_pkg::CNT_W'(N));
        r_last    <= n_last;
    end

    assign busy          = r_busy;
    assign o_valid       = r_valid;
    assign o_ok          = r_ok;
    assign o_key_out     = r_key_out;
    assign o_payload_out = r_pay_out;
    assign o_used_count  = r_used;
    assign o_full_res    = r_full;
    assign o_last        = r_last;

    // valid cells always form a packed prefix matching the count
    a_vld_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(w_vld) == int'(r_count)))
        else $error("cell valid bits disagree with record count");

    a_vld_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_vld & (w_vld + N'(1))) == '0))
        else $error("gap in cell chain");

    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit))
        else $error("duplicate key stored");

    a_busy_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_remain != '0) && (r_remain < r_count))
        else $error("list counter out of range");

    a_list_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !n_busy) |=> (o_valid && o_last && !busy))
        else $error("list did not end with last");

endmodule

// ===== rtl/okrt_cell.sv =====
// One cell of the record chain: a key, a payload and a valid bit.
// Appends, closes gaps on delete and rotates during a listing.
// Depends on okrt_pkg.
module okrt_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  okrt_pkg::t_ctl i_ctl,
    input  logic          i_left_vld,
    input  logic          i_hit_in,
    input  okrt_pkg::t_ent i_right,
    input  okrt_pkg::t_ent i_head,
    output okrt_pkg::t_ent o_ent,
    output logic          o_hit,
    output logic          o_hit_out
);

    logic                             r_vld;
    logic [okrt_pkg::KEY_W-1:0]        r_key;
    logic [okrt_pkg::PAYLOAD_BITS-1:0] r_pay;
    logic                             n_vld;
    logic [okrt_pkg::KEY_W-1:0]        n_key;
    logic [okrt_pkg::PAYLOAD_BITS-1:0] n_pay;

    assign o_hit     = r_vld && (r_key == i_ctl.key);
    assign o_hit_out = i_hit_in || o_hit;
    assign o_ent     = '{vld: r_vld, key: r_key, pay: r_pay};

    always_comb begin
        n_vld = r_vld;
        n_key = r_key;
        n_pay = r_pay;
        if (i_ctl.add && !r_vld && i_left_vld) begin
            n_vld = 1'b1;
            n_key = i_ctl.key;
            n_pay = i_ctl.pay;
        end else if (i_ctl.del && o_hit_out) begin
            n_vld = i_right.vld;
            n_key = i_right.key;
            n_pay = i_right.pay;
        end else if (i_ctl.rot && r_vld) begin
            if (i_right.vld) begin
                n_key = i_right.key;
                n_pay = i_right.pay;
            end else begin
                n_key = i_head.key;
                n_pay = i_head.pay;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        r_key <= n_key;
        r_pay <= n_pay;
    end

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for ordered_keyed_record_table_top.
// A directed request table, then random add/lookup/delete/list traffic checked against a
// behavioural table kept here. Depends on okrt_pkg and the RTL under rtl/.
module tb_top;
    import okrt_pkg::*;

    typedef struct packed {
        logic                  ok;
        logic [KEY_W-1:0]      key_out;
        logic [PORT_PAY_W-1:0] pay_out;
        logic [CNT_W-1:0]      used;
        logic                  full;
        logic                  last;
    } t_rec_result;

    typedef struct {
        logic [OP_W-1:0]       op;
        logic [KEY_W-1:0]      key;
        logic [PORT_PAY_W-1:0] pay;
        int                    reps;
        bit                    typed;
        t_rec_result           want;
    } t_dir_row;

    localparam logic [PORT_PAY_W-1:0] PAY_MASK =
        {PORT_PAY_W{1'b1}} >> (PORT_PAY_W - PAYLOAD_BITS);
    localparam int N_RANDOM = 240;
    localparam int KEY_POOL = 24;
    localparam int N_DIR    = 21;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  start     = 1'b0;
    logic [OP_W-1:0]       i_op      = OP_ADD;
    logic [KEY_W-1:0]      i_key     = '0;
    logic [PORT_PAY_W-1:0] i_payload = '0;
    logic                  busy;
    logic                  o_valid;
    logic                  o_ok;
    logic [KEY_W-1:0]      o_key_out;
    logic [PORT_PAY_W-1:0] o_payload_out;
    logic [CNT_W-1:0]      o_used_count;
    logic                  o_full_res;
    logic                  o_last;

    always #10 i_clk = ~i_clk;

    ordered_keyed_record_table_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_key         (i_key),
        .i_payload     (i_payload),
        .o_valid       (o_valid),
        .o_ok          (o_ok),
        .o_key_out     (o_key_out),
        .o_payload_out (o_payload_out),
        .o_used_count  (o_used_count),
        .o_full_res    (o_full_res),
        .o_last        (o_last)
    );

    // Behavioural copy of the table
    logic [KEY_W-1:0]      tbl_keys [CAPACITY];
    logic [PORT_PAY_W-1:0] tbl_pays [CAPACITY];
    int                    tbl_count = 0;

    t_rec_result      expected_q [$];
    logic [KEY_W-1:0] key_pool [KEY_POOL];
    bit               idle_en     = 1'b1;
    int               err_cnt     = 0;
    int               chk_cnt     = 0;
    int               req_cnt     = 0;
    int               list_cnt    = 0;
    int               refused_cnt = 0;

    t_dir_row directed [N_DIR] = '{
        '{OP_LIST,   32'h0000_0000, 64'h0, 1, 1'b1, {1'b0, 32'h0, 64'h0, 5'd0, 1'b0, 1'b1}},
        '{OP_LOOKUP, 32'h0000_0000, 64'h0, 1, 1'b1, {1'b0, 32'h0, 64'h0, 5'd0, 1'b0, 1'b1}},
        '{OP_DELETE, 32'hFFFF_FFFF, 64'h0, 1, 1'b1, {1'b0, 32'h0, 64'h0, 5'd0, 1'b0, 1'b1}},
        '{OP_ADD,    32'h0000_0000, 64'h0, 1, 1'b1, {1'b1, 32'h0, 64'h0, 5'd1, 1'b0, 1'b1}},
        '{OP_ADD,    32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1'b1,
          {1'b1, 32'h0, 64'h0, 5'd2, 1'b0, 1'b1}},
        '{OP_ADD,    32'h0000_0000, 64'h5555_5555_5555_5555, 1, 1'b1,
          {1'b0, 32'h0, 64'h0, 5'd2, 1'b0, 1'b1}},
        '{OP_LOOKUP, 32'hFFFF_FFFF, 64'h0, 1, 1'b1,
          {1'b1, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 5'd2, 1'b0, 1'b1}},
        '{OP_LOOKUP, 32'h0000_0000, 64'h0, 1, 1'b1, {1'b1, 32'h0, 64'h0, 5'd2, 1'b0, 1'b1}},
        '{OP_LIST,   32'h0000_0000, 64'h0, 1, 1'b0, '0},
        '{OP_ADD,    32'h0000_0100, 64'hAAAA_AAAA_AAAA_AAA0, 14, 1'b0, '0},
        '{OP_ADD,    32'h1234_5678, 64'h1, 1, 1'b1, {1'b0, 32'h0, 64'h0, 5'd16, 1'b1, 1'b1}},
        '{OP_LOOKUP, 32'h0000_0107, 64'h0, 1, 1'b0, '0},
        '{OP_LIST,   32'h0000_0000, 64'h0, 1, 1'b0, '0},
        '{OP_DELETE, 32'h0000_0107, 64'h0, 1, 1'b0, '0},
        '{OP_ADD,    32'h8000_0000, 64'h8000_0000_0000_0001, 1, 1'b0, '0},
        '{OP_DELETE, 32'h0000_0000, 64'h0, 1, 1'b0, '0},
        '{OP_DELETE, 32'h8000_0000, 64'h0, 1, 1'b0, '0},
        '{OP_DELETE, 32'h8000_0000, 64'h0, 1, 1'b1, {1'b0, 32'h0, 64'h0, 5'd14, 1'b0, 1'b1}},
        '{OP_LOOKUP, 32'h0000_0107, 64'h0, 1, 1'b1, {1'b0, 32'h0, 64'h0, 5'd14, 1'b0, 1'b1}},
        '{OP_LIST,   32'h0000_0000, 64'h0, 1, 1'b0, '0},
        '{OP_LOOKUP, 32'h7FFF_FFFF, 64'hFFFF, 1, 1'b1,
          {1'b0, 32'h0, 64'h0, 5'd14, 1'b0, 1'b1}}
    };

    function automatic t_rec_result mk_res(bit ok, logic [KEY_W-1:0] k,
                                           logic [PORT_PAY_W-1:0] p, bit last);
        t_rec_result r;
        r.ok      = ok;
        r.key_out = k;
        r.pay_out = p;
        r.used    = CNT_W'(tbl_count);
        r.full    = (tbl_count >= CAPACITY);
        r.last    = last;
        return r;
    endfunction

    function automatic int find_slot(logic [KEY_W-1:0] k);
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_keys[i] == k) return i;
        end
        return -1;
    endfunction

    task automatic table_apply(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                               input logic [PORT_PAY_W-1:0] p, output t_rec_result outs[$]);
        int slot;
        outs = {};
        slot = find_slot(k);
        case (op)
            OP_ADD: begin
                if (tbl_count >= CAPACITY || slot >= 0) begin
                    if (tbl_count >= CAPACITY) refused_cnt++;
                    outs.push_back(mk_res(1'b0, '0, '0, 1'b1));
                end else begin
                    tbl_keys[tbl_count] = k;
                    tbl_pays[tbl_count] = p & PAY_MASK;
                    tbl_count++;
                    outs.push_back(mk_res(1'b1, '0, '0, 1'b1));
                end
            end
            OP_LOOKUP: begin
                if (slot >= 0) outs.push_back(mk_res(1'b1, '0, tbl_pays[slot], 1'b1));
                else outs.push_back(mk_res(1'b0, '0, '0, 1'b1));
            end
            OP_DELETE: begin
                if (slot >= 0) begin
                    for (int i = slot; i + 1 < tbl_count; i++) begin
                        tbl_keys[i] = tbl_keys[i+1];
                        tbl_pays[i] = tbl_pays[i+1];
                    end
                    tbl_count--;
                    outs.push_back(mk_res(1'b1, '0, '0, 1'b1));
                end else begin
                    outs.push_back(mk_res(1'b0, '0, '0, 1'b1));
                end
            end
            OP_LIST: begin
                list_cnt++;
                if (tbl_count == 0) outs.push_back(mk_res(1'b0, '0, '0, 1'b1));
                for (int i = 0; i < tbl_count; i++)
                    outs.push_back(mk_res(1'b1, tbl_keys[i], '0, i + 1 == tbl_count));
            end
        endcase
    endtask

    task automatic send_req(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                            input logic [PORT_PAY_W-1:0] p, input bit typed,
                            input t_rec_result want);
        t_rec_result outs [$];
        if (idle_en && $urandom_range(0, 99) < 6) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_op      <= op;
        i_key     <= k;
        i_payload <= p;
        do @(posedge i_clk); while (busy);
        table_apply(op, k, p, outs);
        req_cnt++;
        if (typed) expected_q.push_back(want);
        else expected_q = {expected_q, outs};
    endtask

    always @(posedge i_clk) begin : result_check
        t_rec_result want;
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                $error("result with no request outstanding");
                err_cnt++;
            end else begin
                want = expected_q.pop_front();
                chk_cnt++;
                if (o_ok !== want.ok) begin
                    $error("ok: expected %0h, got %0h", want.ok, o_ok);
                    err_cnt++;
                end
                if (o_key_out !== want.key_out) begin
                    $error("key_out: expected %h, got %h", want.key_out, o_key_out);
                    err_cnt++;
                end
                if (o_payload_out !== want.pay_out) begin
                    $error("payload_out: expected %h, got %h", want.pay_out, o_payload_out);
                    err_cnt++;
                end
                if (o_used_count !== want.used) begin
                    $error("used_count: expected %0d, got %0d", want.used, o_used_count);
                    err_cnt++;
                end
                if (o_full_res !== want.full) begin
                    $error("full_res: expected %0h, got %0h", want.full, o_full_res);
                    err_cnt++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0h, got %0h", want.last, o_last);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        logic [OP_W-1:0]       op;
        logic [KEY_W-1:0]      k;
        logic [PORT_PAY_W-1:0] p;
        t_rec_result           no_want;
        int                    r;
        bit                    fill_phase;
        no_want = '0;
        foreach (key_pool[i]) key_pool[i] = $urandom;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) begin
            for (int j = 0; j < directed[i].reps; j++)
                send_req(directed[i].op, directed[i].key + j, directed[i].pay + j,
                         directed[i].typed, directed[i].want);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            idle_en = !(n >= 60 && n < 160);
            // hold off until the table has answered everything
            if (n == 125 || n == 200) begin
                start <= 1'b0;
                do @(posedge i_clk); while (expected_q.size() != 0);
            end
            fill_phase = ((n / 40) % 2) == 1;
            r = $urandom_range(0, 99);
            if (fill_phase)
                op = (r < 55) ? OP_ADD : (r < 75) ? OP_LOOKUP : (r < 90) ? OP_DELETE : OP_LIST;
            else
                op = (r < 15) ? OP_ADD : (r < 35) ? OP_LOOKUP : (r < 90) ? OP_DELETE : OP_LIST;
            r = $urandom_range(0, 99);
            if (r < 45 && tbl_count > 0) k = tbl_keys[$urandom_range(0, tbl_count - 1)];
            else if (r < 85) k = key_pool[$urandom_range(0, KEY_POOL - 1)];
            else k = $urandom;
            p = {$urandom, $urandom};
            send_req(op, k, p, 1'b0, no_want);
        end
        start <= 1'b0;

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("%0d requests driven (%0d directed rows), %0d results checked",
                 req_cnt, N_DIR, chk_cnt);
        $display("%0d list requests, %0d adds refused on a full table", list_cnt, refused_cnt);
        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2000000;
        $error("timeout with %0d results outstanding", expected_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
